// File: src/dscq_pkg.sv
// Package with command codes, status codes and stream field widths for the command queue.
`default_nettype none
package dscq_pkg;
  localparam logic [2:0] KIND_PUSH    = 3'd0;
  localparam logic [2:0] KIND_DEQUEUE = 3'd1;
  localparam logic [2:0] KIND_ABANDON = 3'd2;
  localparam logic [2:0] KIND_CLEAR   = 3'd3;
  localparam logic [2:0] KIND_DRAIN   = 3'd4;

  localparam logic [2:0] ST_ITEM   = 3'd0;
  localparam logic [2:0] ST_NONE   = 3'd1;
  localparam logic [2:0] ST_PUSHED = 3'd2;
  localparam logic [2:0] ST_FULL   = 3'd3;
  localparam logic [2:0] ST_DONE   = 3'd4;

  localparam int IN_BITS  = 48 + 48 + 48 + 16 + 32;
  localparam int IN_BYTES = (IN_BITS + 7) / 8;
  localparam int OUT_BITS = 16 + 1 + 5 + 5;
  localparam int OUT_BYTES = (OUT_BITS + 7) / 8;
  localparam int ORDER_BITS = 32;
endpackage
`default_nettype wire

// File: src/dscq_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
`default_nettype none
module dscq_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  wire                     clk_i,
  input  wire                     we_i,
  input  wire [$clog2(Depth)-1:0] waddr_i,
  input  wire [Width-1:0]         wdata_i,
  input  wire [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]        rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule
`default_nettype wire

// File: src/deadline_scheduled_command_queue.sv
// Top level of the deadline-scheduled command queue.
`default_nettype none
// Pending commands sit in one RAM row per slot (scheduled time, timeout, tag, insertion order)
// with a valid bit per slot in flip-flops. A table scan reads the RAM one slot a cycle; these
// scans set the time a request needs. Push writes a free slot (a full table is answered
// directly), clear and unknown kinds are answered directly, abandon computes its limit and
// then runs one scan, dequeue scans by timeout and, when no timeout has passed, by scheduled
// time, then fetches the due row if any, and drain runs one scan per returned command (one on
// an empty table). A new request is taken only after the previous one has been answered
// completely, once its last result has been taken; a result waits in the output register
// while the receiver stalls, and a drain goes on with its next scan meanwhile.
module deadline_scheduled_command_queue #(
  parameter int CAPACITY  = 16,
  parameter int TIME_BITS = 48
) (
  input  wire                                clk_i,
  input  wire                                rst_ni,
  input  wire                                s_axis_tvalid,
  output logic                               s_axis_tready,
  // kind[2:0]
  input  wire [2:0]                          s_axis_tuser,
  // now_us[47:0], scheduled_time[95:48], timeout_time[143:96], command_tag[159:144],
  // window_ms[191:160]
  input  wire [dscq_pkg::IN_BYTES*8-1:0]     s_axis_tdata,
  output logic                               m_axis_tvalid,
  input  wire                                m_axis_tready,
  // status[2:0]
  output logic [2:0]                         m_axis_tuser,
  // result_tag[15:0], via_timeout[16], removed_count[21:17], occupancy[26:22]
  output logic [dscq_pkg::OUT_BYTES*8-1:0]   m_axis_tdata,
  output logic                               m_axis_tlast
);
  localparam int IW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int OW = dscq_pkg::ORDER_BITS;
  localparam int RW = 2 * TIME_BITS + 16 + OW;

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_PUSH   = 4'd1;
  localparam logic [3:0] S_SCAN_T = 4'd2;
  localparam logic [3:0] S_SCAN_S = 4'd3;
  localparam logic [3:0] S_ABAN   = 4'd4;
  localparam logic [3:0] S_FETCH  = 4'd5;
  localparam logic [3:0] S_FDATA  = 4'd6;
  localparam logic [3:0] S_OUT    = 4'd7;
  localparam logic [3:0] S_LIM    = 4'd8;

  logic [3:0] state_q, state_d;
  logic [2:0] kind_q;
  logic [47:0] now_q;
  logic [TIME_BITS-1:0] sch_in_q, tmo_in_q;
  logic [15:0] tag_in_q;
  logic signed [31:0] win_q;
  logic signed [65:0] lim_q;
  logic [CAPACITY-1:0] valid_q, valid_d;
  logic [OW-1:0] ctr_q;
  logic [IW:0] idx_q;           // scan issue counter, one wider to hold CAPACITY
  logic rv_q;                   // RAM read data valid for slot ridx_q
  logic [IW-1:0] ridx_q;
  logic best_v_q;
  logic [IW-1:0] best_i_q;
  logic [TIME_BITS-1:0] best_k_q;
  logic [OW-1:0] best_o_q;
  logic [CW-1:0] rem_q;
  logic via_q;
  logic [IW-1:0] slot_q;
  logic push_ok_q;
  logic [15:0] fetch_tag_q;

  logic [2:0] o_st_q;
  logic [15:0] o_tag_q;
  logic o_via_q, o_last_q;
  logic [4:0] o_rem_q;

  logic we;
  logic [IW-1:0] waddr, raddr;
  logic [RW-1:0] wdata, rdata;

  dscq_ram #(.Width(RW), .Depth(2 ** IW)) u_ram (
    .clk_i(clk_i), .we_i(we), .waddr_i(waddr), .wdata_i(wdata),
    .raddr_i(raddr), .rdata_o(rdata)
  );

  logic [TIME_BITS-1:0] r_sch, r_tmo, r_key;
  logic [15:0] r_tag;
  logic [OW-1:0] r_ord, od_new, od_best;
  assign r_sch = rdata[TIME_BITS-1:0];
  assign r_tmo = rdata[2*TIME_BITS-1:TIME_BITS];
  assign r_tag = rdata[2*TIME_BITS+15:2*TIME_BITS];
  assign r_ord = rdata[RW-1:2*TIME_BITS+16];
  assign r_key = (state_q == S_SCAN_T) ? r_tmo : r_sch;
  assign od_new = r_ord;
  assign od_best = best_o_q;

  logic [47:0] now_m;
  logic [TIME_BITS-1:0] now_t;
  assign now_m = s_axis_tdata[47:0];
  assign now_t = TIME_BITS'(now_q);

  logic signed [65:0] win_x;
  assign win_x = $signed({{34{win_q[31]}}, win_q});

  logic free_found;
  logic [IW-1:0] free_idx;
  always_comb begin
    free_found = 1'b0;
    free_idx = '0;
    for (int i = CAPACITY - 1; i >= 0; i--) begin
      if (!valid_q[i]) begin
        free_found = 1'b1;
        free_idx = IW'(i);
      end
    end
  end

  logic [CW-1:0] occ;
  always_comb begin
    occ = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      occ = occ + CW'(valid_q[i]);
    end
  end

  logic scan_hit, better, due, aban_hit;
  assign scan_hit = rv_q && valid_q[ridx_q];
  assign better = !best_v_q || (r_key < best_k_q) || (r_key == best_k_q && od_new < od_best);
  assign due = best_v_q && (best_k_q <= now_t);
  assign aban_hit = lim_q <= 0 ||
                    {{(66 - TIME_BITS){1'b0}}, r_sch} >= lim_q;

  logic scanning;
  assign scanning = state_q == S_SCAN_T || state_q == S_SCAN_S || state_q == S_ABAN;
  logic scan_end;
  assign scan_end = scanning && idx_q == (IW + 1)'(CAPACITY) && !rv_q;

  assign s_axis_tready = state_q == S_IDLE && !m_axis_tvalid;
  assign we = state_q == S_PUSH;
  assign waddr = slot_q;
  assign wdata = {ctr_q, tag_in_q, tmo_in_q, sch_in_q};
  assign raddr = (state_q == S_FETCH) ? best_i_q : idx_q[IW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      valid_q <= '0;
      ctr_q <= '0;
      m_axis_tvalid <= 1'b0;
      idx_q <= '0;
      rv_q <= 1'b0;
      best_v_q <= 1'b0;
    end else begin
      state_q <= state_d;
      valid_q <= valid_d;
      if (state_q == S_PUSH) begin
        ctr_q <= ctr_q + 1'b1;
      end
      if (m_axis_tvalid && m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
      if (state_q == S_OUT && !m_axis_tvalid) begin
        m_axis_tvalid <= 1'b1;
      end
      if (scanning) begin
        if (scan_end) begin
          idx_q <= '0;
          rv_q <= 1'b0;
          if (!due && (state_q == S_SCAN_T ||
                       (state_q == S_SCAN_S && kind_q != dscq_pkg::KIND_DRAIN))) begin
            best_v_q <= 1'b0;
          end
        end else begin
          rv_q <= idx_q < (IW + 1)'(CAPACITY);
          if (idx_q < (IW + 1)'(CAPACITY)) begin
            idx_q <= idx_q + 1'b1;
          end
          if (scan_hit && state_q != S_ABAN && better) begin
            best_v_q <= 1'b1;
          end
        end
      end else begin
        idx_q <= '0;
        rv_q <= 1'b0;
        if (state_q == S_OUT ? !m_axis_tvalid
                             : (state_q != S_FETCH && state_q != S_FDATA)) begin
          best_v_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    ridx_q <= idx_q[IW-1:0];
    if (s_axis_tvalid && s_axis_tready) begin
      kind_q <= s_axis_tuser;
      now_q <= now_m;
      sch_in_q <= TIME_BITS'(s_axis_tdata[95:48]);
      tmo_in_q <= TIME_BITS'(s_axis_tdata[143:96]);
      tag_in_q <= s_axis_tdata[159:144];
      win_q <= s_axis_tdata[191:160];
      slot_q <= free_idx;
      rem_q <= (s_axis_tuser == dscq_pkg::KIND_CLEAR) ? occ : '0;
    end
    if (state_q == S_LIM) begin
      lim_q <= $signed({18'd0, now_q}) + (win_x <<< 10) - (win_x <<< 4) - (win_x <<< 3);
    end
    if (scanning && scan_hit && state_q != S_ABAN && better) begin
      best_i_q <= ridx_q;
      best_k_q <= r_key;
      best_o_q <= r_ord;
    end
    if (state_q == S_ABAN && scan_hit && aban_hit) begin
      rem_q <= rem_q + 1'b1;
    end
    if (state_q == S_SCAN_T) begin
      via_q <= 1'b1;
    end else if (state_q == S_SCAN_S) begin
      via_q <= 1'b0;
    end
    if (state_q == S_FDATA) begin
      fetch_tag_q <= r_tag;
    end
  end

  logic [CAPACITY-1:0] aban_clr;
  always_comb begin
    aban_clr = '0;
    if (state_q == S_ABAN && scan_hit && aban_hit) begin
      aban_clr[ridx_q] = 1'b1;
    end
  end

  always_comb begin
    state_d = state_q;
    valid_d = valid_q & ~aban_clr;
    unique case (state_q)
      S_IDLE: begin
        if (s_axis_tvalid && s_axis_tready) begin
          unique case (s_axis_tuser)
            dscq_pkg::KIND_PUSH: state_d = free_found ? S_PUSH : S_OUT;
            dscq_pkg::KIND_DEQUEUE: state_d = S_SCAN_T;
            dscq_pkg::KIND_ABANDON: state_d = S_LIM;
            dscq_pkg::KIND_CLEAR: begin
              valid_d = '0;
              state_d = S_OUT;
            end
            dscq_pkg::KIND_DRAIN: state_d = S_SCAN_S;
            default: state_d = S_OUT;
          endcase
        end
      end
      S_PUSH: begin
        valid_d[slot_q] = 1'b1;
        state_d = S_OUT;
      end
      S_LIM: state_d = S_ABAN;
      S_ABAN: if (scan_end) state_d = S_OUT;
      S_SCAN_T: if (scan_end) state_d = due ? S_FETCH : S_SCAN_S;
      S_SCAN_S: if (scan_end) state_d = due || (kind_q == dscq_pkg::KIND_DRAIN && best_v_q)
                                        ? S_FETCH : S_OUT;
      S_FETCH: state_d = S_FDATA;
      S_FDATA: begin
        valid_d[best_i_q] = 1'b0;
        state_d = S_OUT;
      end
      S_OUT: begin
        if (!m_axis_tvalid) begin
          state_d = (kind_q == dscq_pkg::KIND_DRAIN && best_v_q && valid_q != '0)
                    ? S_SCAN_S : S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Output register is loaded on the cycle the result is presented.
  logic drain_item, drain_first_empty;
  assign drain_item = kind_q == dscq_pkg::KIND_DRAIN && best_v_q;
  assign drain_first_empty = kind_q == dscq_pkg::KIND_DRAIN && !best_v_q;
  always_ff @(posedge clk_i) begin
    if (state_q == S_OUT && !m_axis_tvalid) begin
      o_tag_q <= fetch_tag_q;
      unique case (kind_q)
        dscq_pkg::KIND_PUSH: begin
          o_st_q <= push_ok_q ? dscq_pkg::ST_PUSHED : dscq_pkg::ST_FULL;
          o_via_q <= 1'b0;
          o_rem_q <= '0;
          o_last_q <= 1'b1;
        end
        dscq_pkg::KIND_DEQUEUE: begin
          o_st_q <= best_v_q ? dscq_pkg::ST_ITEM : dscq_pkg::ST_NONE;
          o_via_q <= best_v_q & via_q;
          o_rem_q <= '0;
          o_last_q <= 1'b1;
        end
        dscq_pkg::KIND_ABANDON, dscq_pkg::KIND_CLEAR: begin
          o_st_q <= dscq_pkg::ST_DONE;
          o_via_q <= 1'b0;
          o_rem_q <= 5'(rem_q);
          o_last_q <= 1'b1;
        end
        dscq_pkg::KIND_DRAIN: begin
          o_st_q <= drain_item ? dscq_pkg::ST_ITEM : dscq_pkg::ST_DONE;
          o_via_q <= 1'b0;
          o_rem_q <= '0;
          o_last_q <= drain_first_empty || valid_q == '0;
        end
        default: begin
          o_st_q <= dscq_pkg::ST_DONE;
          o_via_q <= 1'b0;
          o_rem_q <= '0;
          o_last_q <= 1'b1;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      push_ok_q <= free_found;
    end
  end

  // Drain occupancy is zero; results of other kinds show the table after the request.
  logic [4:0] occ_out;
  assign occ_out = (kind_q == dscq_pkg::KIND_DRAIN) ? 5'd0 : 5'(occ);

  logic [15:0] tag_out;
  assign tag_out = (o_st_q == dscq_pkg::ST_ITEM) ? o_tag_q : 16'd0;

  assign m_axis_tuser = o_st_q;
  assign m_axis_tdata = {{(dscq_pkg::OUT_BYTES * 8 - dscq_pkg::OUT_BITS){1'b0}},
                         occ_out, o_rem_q, o_via_q, tag_out};
  assign m_axis_tlast = o_last_q;
endmodule
`default_nettype wire

// File: dv/tb.sv
// Testbench for the deadline-scheduled command queue: directed table and random requests.
`timescale 1ns / 1ps
module tb;
  localparam int SLOTS = 16;
  localparam int STALL_LIMIT = 20000;
  localparam logic [47:0] TMAX = 48'hFFFF_FFFF_FFFF;

  typedef struct packed {
    logic [2:0]  status;
    logic [15:0] tag;
    logic        via;
    logic [4:0]  removed;
    logic [4:0]  occ;
    logic        last;
  } answer_t;

  typedef struct {
    logic [2:0]  kind;
    logic [47:0] now;
    logic [47:0] sched;
    logic [47:0] tmo;
    logic [15:0] tag;
    logic [31:0] win;
    bit          has_fixed;
    logic [2:0]  fixed_status;
    logic [4:0]  fixed_removed;
    logic [4:0]  fixed_occ;
  } request_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [2:0] s_axis_tuser = '0;
  logic [dscq_pkg::IN_BYTES*8-1:0] s_axis_tdata = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [2:0] m_axis_tuser;
  logic [dscq_pkg::OUT_BYTES*8-1:0] m_axis_tdata;
  logic m_axis_tlast;

  deadline_scheduled_command_queue uut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tuser(s_axis_tuser), .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tuser(m_axis_tuser), .m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast)
  );

  always #5 clk_i = ~clk_i;

  bit          q_valid [SLOTS];
  logic [47:0] q_sched [SLOTS];
  logic [47:0] q_tmo [SLOTS];
  logic [15:0] q_tag [SLOTS];
  logic [31:0] q_order [SLOTS];
  logic [31:0] q_counter;

  answer_t pending_answers[$];
  int errors = 0;
  int idle_cycles = 0;
  bit rx_hold = 1'b0;
  bit rx_noidle = 1'b0;
  bit tx_noidle = 1'b0;
  request_t directed[$];

  task automatic report(string what);
    errors++;
    $display("%0t mismatch: %s", $realtime, what);
  endtask

  function automatic int earliest(bit by_timeout);
    int best;
    logic [47:0] kb, ki;
    best = -1;
    for (int i = 0; i < SLOTS; i++) begin
      if (!q_valid[i]) continue;
      if (best < 0) begin
        best = i;
        continue;
      end
      ki = by_timeout ? q_tmo[i] : q_sched[i];
      kb = by_timeout ? q_tmo[best] : q_sched[best];
      if (ki < kb || (ki == kb && q_order[i] < q_order[best])) best = i;
    end
    return best;
  endfunction

  function automatic logic [4:0] occupied();
    int n;
    n = 0;
    for (int i = 0; i < SLOTS; i++) n += q_valid[i];
    return n[4:0];
  endfunction

  task automatic predict_queue(request_t r, ref answer_t res[$]);
    answer_t a;
    int slot, t;
    int unsigned rem;
    longint lim;
    res = {};
    a = '{status: dscq_pkg::ST_DONE, tag: '0, via: 1'b0, removed: '0, occ: '0, last: 1'b1};
    case (r.kind)
      dscq_pkg::KIND_PUSH: begin
        slot = -1;
        for (int i = 0; i < SLOTS; i++) if (!q_valid[i] && slot < 0) slot = i;
        if (slot < 0) a.status = dscq_pkg::ST_FULL;
        else begin
          q_valid[slot] = 1'b1;
          q_sched[slot] = r.sched;
          q_tmo[slot] = r.tmo;
          q_tag[slot] = r.tag;
          q_order[slot] = q_counter;
          q_counter++;
          a.status = dscq_pkg::ST_PUSHED;
        end
        res = {res, a};
      end
      dscq_pkg::KIND_DEQUEUE: begin
        t = earliest(1'b1);
        if (t >= 0 && q_tmo[t] <= r.now) begin
          q_valid[t] = 1'b0;
          a.status = dscq_pkg::ST_ITEM; a.tag = q_tag[t]; a.via = 1'b1;
        end else begin
          t = earliest(1'b0);
          if (t >= 0 && q_sched[t] <= r.now) begin
            q_valid[t] = 1'b0;
            a.status = dscq_pkg::ST_ITEM; a.tag = q_tag[t];
          end else a.status = dscq_pkg::ST_NONE;
        end
        res = {res, a};
      end
      dscq_pkg::KIND_ABANDON: begin
        lim = longint'({16'd0, r.now}) + longint'($signed(r.win)) * 1000;
        rem = 0;
        for (int i = 0; i < SLOTS; i++)
          if (q_valid[i] && (lim <= 0 || longint'({16'd0, q_sched[i]}) >= lim)) begin
            q_valid[i] = 1'b0;
            rem++;
          end
        a.removed = rem[4:0];
        res = {res, a};
      end
      dscq_pkg::KIND_CLEAR: begin
        a.removed = occupied();
        for (int i = 0; i < SLOTS; i++) q_valid[i] = 1'b0;
        res = {res, a};
      end
      dscq_pkg::KIND_DRAIN: begin
        t = earliest(1'b0);
        if (t < 0) res = {res, a};
        while (t >= 0) begin
          q_valid[t] = 1'b0;
          a.status = dscq_pkg::ST_ITEM; a.tag = q_tag[t]; a.last = 1'b0;
          res = {res, a};
          t = earliest(1'b0);
        end
        res[$].last = 1'b1;
      end
      default: res = {res, a};
    endcase
    for (int k = 0; k < res.size(); k++) res[k].occ = occupied();
  endtask

  always @(posedge clk_i) begin
    answer_t got, want;
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("Regression FAIL");
        $finish;
      end
      if (m_axis_tvalid && m_axis_tready) begin
        got = '{status: m_axis_tuser, tag: m_axis_tdata[15:0], via: m_axis_tdata[16],
                removed: m_axis_tdata[21:17], occ: m_axis_tdata[26:22], last: m_axis_tlast};
        if (pending_answers.size() == 0) report("result with nothing expected");
        else begin
          want = pending_answers.pop_front();
          if (got.status !== want.status)
            report($sformatf("status %0d want %0d", got.status, want.status));
          if (got.tag !== want.tag) report($sformatf("tag %0h want %0h", got.tag, want.tag));
          if (got.via !== want.via) report($sformatf("via %0b want %0b", got.via, want.via));
          if (got.removed !== want.removed)
            report($sformatf("removed %0d want %0d", got.removed, want.removed));
          if (got.occ !== want.occ) report($sformatf("occ %0d want %0d", got.occ, want.occ));
          if (got.last !== want.last) report($sformatf("last %0b want %0b", got.last, want.last));
        end
      end
    end
  end

  initial begin : receiver
    int n;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (rx_hold) m_axis_tready <= 1'b0;
      else if (!rx_noidle && $urandom_range(0, 5) == 0) begin
        n = $urandom_range(1, 8);
        m_axis_tready <= 1'b0;
        repeat (n - 1) @(negedge clk_i);
      end else m_axis_tready <= 1'b1;
    end
  end

  task automatic send(request_t r);
    answer_t res[$];
    if (!tx_noidle && $urandom_range(0, 4) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(negedge clk_i);
    end
    s_axis_tuser <= r.kind;
    s_axis_tdata <= {r.win, r.tag, r.tmo, r.sched, r.now};
    s_axis_tvalid <= 1'b1;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    predict_queue(r, res);
    if (r.has_fixed && (res[0].status !== r.fixed_status || res[0].removed !== r.fixed_removed
        || res[0].occ !== r.fixed_occ))
      report($sformatf("directed kind %0d disagrees with expected value", r.kind));
    foreach (res[k]) pending_answers = {pending_answers, res[k]};
    @(negedge clk_i);
  endtask

  function automatic request_t mk(logic [2:0] kind, logic [47:0] now, logic [47:0] sched,
                                  logic [47:0] tmo, logic [15:0] tag, logic [31:0] win);
    request_t r;
    r = '{kind: kind, now: now, sched: sched, tmo: tmo, tag: tag, win: win,
          has_fixed: 1'b0, fixed_status: '0, fixed_removed: '0, fixed_occ: '0};
    return r;
  endfunction

  function automatic request_t fixed(request_t r, logic [2:0] st, logic [4:0] rem,
                                     logic [4:0] occ);
    r.has_fixed = 1'b1;
    r.fixed_status = st; r.fixed_removed = rem; r.fixed_occ = occ;
    return r;
  endfunction

  function automatic logic [47:0] rtime();
    logic [47:0] v;
    case ($urandom_range(0, 3))
      0: v = 48'($urandom_range(0, 40));
      1: v = 48'({$urandom, $urandom});
      2: v = 48'hFFFF_FFFF_FFFF - 48'($urandom_range(0, 3));
      default: v = 48'(1000 + $urandom_range(0, 4000));
    endcase
    return v;
  endfunction

  task automatic drain_wait();
    s_axis_tvalid <= 1'b0;
    while (pending_answers.size() != 0) @(negedge clk_i);
    repeat (200) @(negedge clk_i);
  endtask

  initial begin
    request_t r;
    int sz;
    repeat (7) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    directed = {directed, fixed(mk(dscq_pkg::KIND_DEQUEUE, TMAX, 0, 0, 0, 0),
                                dscq_pkg::ST_NONE, 0, 0)};
    directed = {directed, fixed(mk(dscq_pkg::KIND_DRAIN, 0, 0, 0, 0, 0),
                                dscq_pkg::ST_DONE, 0, 0)};
    directed = {directed, fixed(mk(3'd7, 0, 0, 0, 0, 0), dscq_pkg::ST_DONE, 0, 0)};
    directed = {directed, fixed(mk(3'd5, TMAX, TMAX, TMAX, 16'hFFFF, '1),
                                dscq_pkg::ST_DONE, 0, 0)};
    directed = {directed, fixed(mk(dscq_pkg::KIND_PUSH, 0, 100, TMAX, 16'hFFFF, 0),
                                dscq_pkg::ST_PUSHED, 0, 1)};
    directed = {directed, fixed(mk(dscq_pkg::KIND_PUSH, 0, 100, 50, 16'h0001, 0),
                                dscq_pkg::ST_PUSHED, 0, 2)};
    directed = {directed, fixed(mk(dscq_pkg::KIND_PUSH, 0, 100, TMAX, 16'h0002, 0),
                                dscq_pkg::ST_PUSHED, 0, 3)};
    directed = {directed, fixed(mk(dscq_pkg::KIND_PUSH, 0, TMAX, TMAX, 16'hA5A5, 0),
                                dscq_pkg::ST_PUSHED, 0, 4)};
    directed = {directed, mk(dscq_pkg::KIND_DEQUEUE, 49, 0, 0, 0, 0)};
    directed = {directed, mk(dscq_pkg::KIND_DEQUEUE, 50, 0, 0, 0, 0)};
    directed = {directed, mk(dscq_pkg::KIND_DEQUEUE, 100, 0, 0, 0, 0)};
    directed = {directed, mk(dscq_pkg::KIND_ABANDON, 0, 0, 0, 0, 32'h7FFF_FFFF)};
    directed = {directed, mk(dscq_pkg::KIND_ABANDON, TMAX, 0, 0, 0, 32'h7FFF_FFFF)};
    directed = {directed, mk(dscq_pkg::KIND_ABANDON, 0, 0, 0, 0, 32'h8000_0000)};
    for (int i = 0; i < 17; i++)
      directed = {directed, mk(dscq_pkg::KIND_PUSH, 0, 48'd5000 - i * 7, TMAX, i[15:0], 0)};
    directed = {directed, fixed(mk(dscq_pkg::KIND_PUSH, 0, 1, 1, 16'hDEAD, 0),
                                dscq_pkg::ST_FULL, 0, 16)};
    directed = {directed, mk(dscq_pkg::KIND_ABANDON, 4950, 0, 0, 0, 0)};
    directed = {directed, mk(dscq_pkg::KIND_DRAIN, 0, 0, 0, 0, 0)};
    foreach (directed[i]) send(directed[i]);
    drain_wait();

    for (int i = 0; i < 216; i++) begin
      if (i == 100) drain_wait();
      if (i == 50) begin
        fork
          begin
            rx_hold = 1'b1;
            repeat (600) @(negedge clk_i);
            rx_hold = 1'b0;
          end
        join_none
      end
      if (i >= 180) begin
        tx_noidle = 1'b1;
        rx_noidle = 1'b1;
      end
      sz = $urandom_range(0, 99);
      if (sz < 45) r = mk(dscq_pkg::KIND_PUSH, 0, rtime(), rtime(), 16'($urandom), 0);
      else if (sz < 75) r = mk(dscq_pkg::KIND_DEQUEUE, rtime(), 0, 0, 0, 0);
      else if (sz < 85) r = mk(dscq_pkg::KIND_ABANDON, rtime(), 0, 0, 0,
                               $urandom_range(0, 1) ? $urandom : $urandom_range(0, 8) - 4);
      else if (sz < 89) r = mk(dscq_pkg::KIND_CLEAR, 0, 0, 0, 0, 0);
      else if (sz < 95) r = mk(dscq_pkg::KIND_DRAIN, 0, 0, 0, 0, 0);
      else r = mk(3'($urandom_range(5, 7)), rtime(), rtime(), rtime(), 16'($urandom),
                  $urandom);
      if (sz >= 95 || $urandom_range(0, 7) == 0) begin
        r.now = 48'({$urandom, $urandom}); r.sched = 48'({$urandom, $urandom});
        r.tmo = 48'({$urandom, $urandom}); r.tag = 16'($urandom); r.win = $urandom;
      end
      send(r);
    end

    drain_wait();
    if (errors == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end
endmodule

// File: filelist.f
src/dscq_pkg.sv
src/dscq_ram.sv
src/deadline_scheduled_command_queue.sv
dv/tb.sv
